/* rtl/u8vc_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// u8vc_pkg: shared types and constants for the UTF-8 validate/count core
// Item and result structs, byte class constants and continuation rule codes.
// ----------------------------------------------------------------------------
package u8vc_pkg;

  // Input item: one string byte (or none) plus end-of-string flag
  typedef struct packed {
    logic       has_byte;
    logic [7:0] data_byte;
    logic       last;
  } in_item_t;

  // Result item: well-formed flag and code point count
  typedef struct packed {
    logic        valid_res;
    logic [12:0] codepoint_count;
  } res_item_t;

  localparam int unsigned CNT_OUT_W = 13;

  // Rule for the first continuation byte after a lead byte
  localparam logic [1:0] RULE_NONE = 2'd0;  // plain 80..BF
  localparam logic [1:0] RULE_E0   = 2'd1;  // needs A0..BF
  localparam logic [1:0] RULE_F0   = 2'd2;  // needs 90..BF
  localparam logic [1:0] RULE_F4   = 2'd3;  // needs 80..8F

  // Byte boundaries
  localparam logic [7:0] BYTE_ASCII_END = 8'h80;
  localparam logic [7:0] BYTE_LEAD2_MIN = 8'hC2;
  localparam logic [7:0] BYTE_LEAD3     = 8'hE0;
  localparam logic [7:0] BYTE_LEAD4     = 8'hF0;
  localparam logic [7:0] BYTE_LEAD4_MAX = 8'hF4;
  localparam logic [7:0] BYTE_E0_CONT   = 8'hA0;
  localparam logic [7:0] BYTE_F0_CONT   = 8'h90;
  localparam logic [7:0] BYTE_F4_CONT   = 8'h8F;

endpackage : u8vc_pkg
`default_nettype wire

/* rtl/utf8_validate_count_core.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// utf8_validate_count_core: streaming UTF-8 validator and code point counter
// Checks a byte stream for well-formed UTF-8 and counts code points,
// giving one result per string on the item that carries last.
// ----------------------------------------------------------------------------
// The core takes one item per clock cycle with no gaps: an accepted item is
// held in an input register and decoded by a single short stage that updates
// the sequence state and, for the final item of a string, loads the result
// register. The result register loads when the final item leaves the input
// register, so the result is offered from the result register behind it.
// The input side stalls only while the input register holds a final item and
// the result register still holds an untaken result. Invalid strings give
// valid_res = 0 with a zero count; the count saturates at MAX_LEN and the
// output carries its low 13 bits. Surrogates are not rejected.
module utf8_validate_count_core #(
  parameter int unsigned MAX_LEN = 4096
) (
  input  wire                        clk,
  input  wire                        rst,
  // item channel
  input  wire                        item_valid,
  output logic                       item_stall,
  input  wire u8vc_pkg::in_item_t    item,
  // result channel
  output logic                       result_valid,
  input  wire                        result_stall,
  output u8vc_pkg::res_item_t        result
);

  import u8vc_pkg::*;

  localparam int unsigned CNT_W = $clog2(MAX_LEN + 1);
  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_LEN);

  // Input register
  logic     s1_valid;
  in_item_t s1_item;

  // Sequence state
  logic [1:0]       bytes_pending,   bytes_pending_next;
  logic [1:0]       first_cont_rule, first_cont_rule_next;
  logic             error_seen,      error_seen_next;
  logic [CNT_W-1:0] running_count,   running_count_next;

  // Decode intermediates
  logic             cont_ok;
  logic             count_inc;
  logic [CNT_W-1:0] count_sat;
  logic             str_ok;
  logic [CNT_W+CNT_OUT_W-1:0] count_ext;

  // Handshake
  logic out_free;
  logic s1_fire;
  logic item_take;

  assign out_free   = !result_valid || !result_stall;
  assign s1_fire    = s1_valid && (!s1_item.last || out_free);
  assign item_stall = s1_valid && !s1_fire;
  assign item_take  = item_valid && !item_stall;

  // Input register load
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (item_take) begin
      s1_valid <= 1'b1;
    end else if (s1_fire) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (item_take) begin
      s1_item <= item;
    end
  end

  // Byte decode and state update
  always_comb begin
    bytes_pending_next   = bytes_pending;
    first_cont_rule_next = first_cont_rule;
    error_seen_next      = error_seen;
    count_inc            = 1'b0;
    cont_ok              = (s1_item.data_byte[7:6] == 2'b10);

    unique case (first_cont_rule)
      RULE_E0: if (s1_item.data_byte < BYTE_E0_CONT) cont_ok = 1'b0;
      RULE_F0: if (s1_item.data_byte < BYTE_F0_CONT) cont_ok = 1'b0;
      RULE_F4: if (s1_item.data_byte > BYTE_F4_CONT) cont_ok = 1'b0;
      default: ;
    endcase

    if (s1_item.has_byte && !error_seen) begin
      first_cont_rule_next = RULE_NONE;
      if (bytes_pending == 2'd0) begin
        // lead byte
        priority if (s1_item.data_byte < BYTE_ASCII_END) begin
          count_inc = 1'b1;
        end else if (s1_item.data_byte >= BYTE_LEAD2_MIN &&
                     s1_item.data_byte < BYTE_LEAD3) begin
          bytes_pending_next = 2'd1;
        end else if (s1_item.data_byte[7:4] == BYTE_LEAD3[7:4]) begin
          bytes_pending_next = 2'd2;
          if (s1_item.data_byte == BYTE_LEAD3) first_cont_rule_next = RULE_E0;
        end else if (s1_item.data_byte[7:3] == BYTE_LEAD4[7:3] &&
                     s1_item.data_byte <= BYTE_LEAD4_MAX) begin
          bytes_pending_next = 2'd3;
          if (s1_item.data_byte == BYTE_LEAD4) begin
            first_cont_rule_next = RULE_F0;
          end else if (s1_item.data_byte == BYTE_LEAD4_MAX) begin
            first_cont_rule_next = RULE_F4;
          end
        end else begin
          error_seen_next = 1'b1;
        end
      end else begin
        // continuation byte
        if (!cont_ok) begin
          error_seen_next    = 1'b1;
          bytes_pending_next = 2'd0;
        end else begin
          bytes_pending_next = bytes_pending - 2'd1;
          count_inc          = (bytes_pending == 2'd1);
        end
      end
    end

    count_sat = running_count;
    if (count_inc && running_count < MAX_CNT) count_sat = running_count + CNT_W'(1);
    running_count_next = count_sat;

    str_ok    = !error_seen_next && (bytes_pending_next == 2'd0);
    count_ext = {{CNT_OUT_W{1'b0}}, count_sat};
  end

  // State registers: cleared at end of string
  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_pending   <= 2'd0;
      first_cont_rule <= RULE_NONE;
      error_seen      <= 1'b0;
      running_count   <= '0;
    end else if (s1_fire) begin
      if (s1_item.last) begin
        bytes_pending   <= 2'd0;
        first_cont_rule <= RULE_NONE;
        error_seen      <= 1'b0;
        running_count   <= '0;
      end else begin
        bytes_pending   <= bytes_pending_next;
        first_cont_rule <= first_cont_rule_next;
        error_seen      <= error_seen_next;
        running_count   <= running_count_next;
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (s1_fire && s1_item.last) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && s1_item.last) begin
      result.valid_res       <= str_ok;
      result.codepoint_count <= str_ok ? count_ext[CNT_OUT_W-1:0] : '0;
    end
  end

  // Checks
  a_err_no_pending: assert property (@(posedge clk) disable iff (rst)
    error_seen |-> (bytes_pending == 2'd0))
    else $error("pending bytes while error is set");

  a_rule_has_pending: assert property (@(posedge clk) disable iff (rst)
    (first_cont_rule != RULE_NONE) |-> (bytes_pending == 2'd2 || bytes_pending == 2'd3))
    else $error("continuation rule without a pending sequence");

  a_count_sat: assert property (@(posedge clk) disable iff (rst)
    running_count <= MAX_CNT)
    else $error("code point count beyond saturation");

  a_bad_zero: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !result.valid_res) |-> (result.codepoint_count == '0))
    else $error("invalid result with nonzero count");

  a_last_held: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && s1_item.last && result_valid && result_stall) |=> s1_valid)
    else $error("final item dropped while result stalled");

endmodule : utf8_validate_count_core
`default_nettype wire

/* sim/utf8_validate_count_checker.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// utf8_validate_count_checker: result prediction and comparison
// Watches both channels of the UTF-8 validate/count core. It keeps its own
// decoder state, predicts one verdict per string and compares each accepted
// result with the oldest prediction.
// ----------------------------------------------------------------------------
module utf8_validate_count_checker #(
  parameter int unsigned MAX_LEN = 4096
) (
  input  wire                       clk,
  input  wire                       rst,
  input  wire                       item_valid,
  input  wire                       item_stall,
  input  wire u8vc_pkg::in_item_t   item,
  input  wire                       result_valid,
  input  wire                       result_stall,
  input  wire u8vc_pkg::res_item_t  result,
  output int                        fail_count,
  output int                        outstanding
);

  import u8vc_pkg::*;

  // Decoder state, cleared at reset and at the end of each string
  logic [1:0]  cont_left;
  logic [1:0]  cont_rule;
  logic        err_seen;
  int unsigned cp_count;

  res_item_t   expected_verdicts[$];
  int          errors;

  // Feed one string byte through the sequence decoder
  task automatic take_octet(input logic [7:0] b);
    logic ok;
    if (err_seen) return;
    if (cont_left == 2'd0) begin
      cont_rule = RULE_NONE;
      if (b < BYTE_ASCII_END) begin
        if (cp_count < MAX_LEN) cp_count++;
      end else if (b >= BYTE_LEAD2_MIN && b < BYTE_LEAD3) begin
        cont_left = 2'd1;
      end else if (b[7:4] == 4'hE) begin
        cont_left = 2'd2;
        if (b == BYTE_LEAD3) cont_rule = RULE_E0;
      end else if (b[7:3] == 5'b11110 && b <= BYTE_LEAD4_MAX) begin
        cont_left = 2'd3;
        if (b == BYTE_LEAD4) cont_rule = RULE_F0;
        else if (b == BYTE_LEAD4_MAX) cont_rule = RULE_F4;
      end else begin
        err_seen = 1'b1;
      end
      return;
    end
    // continuation byte, with the tighter range right after E0, F0 or F4
    ok = (b[7:6] == 2'b10);
    if (cont_rule == RULE_E0 && b < BYTE_E0_CONT) ok = 1'b0;
    if (cont_rule == RULE_F0 && b < BYTE_F0_CONT) ok = 1'b0;
    if (cont_rule == RULE_F4 && b > BYTE_F4_CONT) ok = 1'b0;
    cont_rule = RULE_NONE;
    if (!ok) begin
      err_seen  = 1'b1;
      cont_left = 2'd0;
    end else begin
      cont_left = cont_left - 2'd1;
      if (cont_left == 2'd0 && cp_count < MAX_LEN) cp_count++;
    end
  endtask

  // Compare results first, then predict from the item taken at this edge
  always @(posedge clk) begin
    res_item_t want;
    if (rst) begin
      cont_left = 2'd0;
      cont_rule = RULE_NONE;
      err_seen  = 1'b0;
      cp_count  = 0;
      errors    = 0;
      expected_verdicts.delete();
    end else begin
      if (result_valid && !result_stall) begin
        if (expected_verdicts.size() == 0) begin
          $error("result with none expected: valid_res %0d codepoint_count %0d",
                 result.valid_res, result.codepoint_count);
          errors++;
        end else begin
          want = expected_verdicts.pop_front();
          if (result.valid_res !== want.valid_res) begin
            $error("valid_res: expected %0d, got %0d", want.valid_res, result.valid_res);
            errors++;
          end
          if (result.codepoint_count !== want.codepoint_count) begin
            $error("codepoint_count: expected %0d, got %0d",
                   want.codepoint_count, result.codepoint_count);
            errors++;
          end
        end
      end
      if (item_valid && !item_stall) begin
        if (item.has_byte) take_octet(item.data_byte);
        if (item.last) begin
          want.valid_res       = !err_seen && (cont_left == 2'd0);
          want.codepoint_count = want.valid_res ? cp_count[CNT_OUT_W-1:0] : '0;
          expected_verdicts.insert(expected_verdicts.size(), want);
          cont_left = 2'd0;
          cont_rule = RULE_NONE;
          err_seen  = 1'b0;
          cp_count  = 0;
        end
      end
    end
    fail_count  <= errors;
    outstanding <= expected_verdicts.size();
  end

endmodule : utf8_validate_count_checker
`default_nettype wire

/* sim/utf8_validate_count_core_tb.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// utf8_validate_count_core_tb: testbench for the UTF-8 validate/count core
// Drives directed strings, a long string sent back to back and random
// well-formed and broken strings, with random gaps on the item side
// and random stalls on the result side. The checker judges every result.
// ----------------------------------------------------------------------------
module utf8_validate_count_core_tb;
  import u8vc_pkg::*;

  localparam int unsigned MAX_LEN      = 4096;
  localparam int          RANDOM_ITEMS = 1500;
  localparam int unsigned CYCLE_LIMIT  = 600000;

  typedef logic [7:0] octet_q_t[$];

  logic      clk          = 1'b0;
  logic      rst          = 1'b1;
  logic      item_valid   = 1'b0;
  logic      item_stall;
  in_item_t  item         = '0;
  logic      result_valid;
  logic      result_stall = 1'b0;
  res_item_t result;

  int          fail_count;
  int          outstanding;
  int          items_sent   = 0;
  bit          quiet        = 1'b0;
  int          hold_cnt     = 0;
  int unsigned cycle_count  = 0;

  utf8_validate_count_core #(
    .MAX_LEN (MAX_LEN)
  ) DUT (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

  utf8_validate_count_checker #(
    .MAX_LEN (MAX_LEN)
  ) u_checker (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .fail_count   (fail_count),
    .outstanding  (outstanding)
  );

  // 20 unit clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Mostly no gap, some short, a few long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    if (r < 94) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Random stalls on the result side
  always @(posedge clk) begin
    int g;
    if (rst) begin
      result_stall <= 1'b0;
      hold_cnt     <= 0;
    end else if (hold_cnt > 0) begin
      hold_cnt <= hold_cnt - 1;
    end else begin
      g = pick_gap();
      result_stall <= (g != 0);
      hold_cnt     <= (g > 0) ? g - 1 : 0;
    end
  end

  // Run watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("utf8_validate_count_core_tb: errors");
      $finish;
    end
  end

  // Append one byte to the end of a string
  function automatic void add_octet(ref octet_q_t q, input logic [7:0] b);
    q.insert(q.size(), b);
  endfunction

  // Append one well-formed character, all lead classes and first-byte rules
  function automatic void add_char(ref octet_q_t q);
    int         kind;
    logic [7:0] lead;
    kind = $urandom_range(0, 9);
    if (kind < 4) begin
      add_octet(q, 8'($urandom_range(0, 8'h7F)));
    end else if (kind < 6) begin
      add_octet(q, 8'($urandom_range(BYTE_LEAD2_MIN, 8'hDF)));
      add_octet(q, 8'($urandom_range(8'h80, 8'hBF)));
    end else if (kind < 8) begin
      lead = 8'($urandom_range(BYTE_LEAD3, 8'hEF));
      add_octet(q, lead);
      if (lead == BYTE_LEAD3) add_octet(q, 8'($urandom_range(BYTE_E0_CONT, 8'hBF)));
      else add_octet(q, 8'($urandom_range(8'h80, 8'hBF)));
      add_octet(q, 8'($urandom_range(8'h80, 8'hBF)));
    end else begin
      lead = 8'($urandom_range(BYTE_LEAD4, BYTE_LEAD4_MAX));
      add_octet(q, lead);
      if (lead == BYTE_LEAD4) add_octet(q, 8'($urandom_range(BYTE_F0_CONT, 8'hBF)));
      else if (lead == BYTE_LEAD4_MAX) add_octet(q, 8'($urandom_range(8'h80, BYTE_F4_CONT)));
      else add_octet(q, 8'($urandom_range(8'h80, 8'hBF)));
      add_octet(q, 8'($urandom_range(8'h80, 8'hBF)));
      add_octet(q, 8'($urandom_range(8'h80, 8'hBF)));
    end
  endfunction

  // Offer one item after an optional gap, return once it is taken
  task automatic send_item(input in_item_t it);
    int gap;
    gap = quiet ? 0 : pick_gap();
    if (gap > 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_valid <= 1'b1;
    item       <= it;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    items_sent++;
  endtask

  // Send a string; optionally close it with an item that carries no byte
  task automatic send_string(input octet_q_t q, input bit close_empty, input bit fillers);
    in_item_t it;
    for (int i = 0; i < q.size(); i++) begin
      if (fillers && $urandom_range(0, 7) == 0) begin
        it.has_byte  = 1'b0;
        it.data_byte = 8'($urandom);
        it.last      = 1'b0;
        send_item(it);
      end
      it.has_byte  = 1'b1;
      it.data_byte = q[i];
      it.last      = !close_empty && (i == q.size() - 1);
      send_item(it);
    end
    if (close_empty || q.size() == 0) begin
      it.has_byte  = 1'b0;
      it.data_byte = 8'($urandom);
      it.last      = 1'b1;
      send_item(it);
    end
  endtask

  // Hold the sender until every predicted result has been taken
  task automatic wait_for_results();
    item_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  // Stimulus and verdict
  initial begin
    octet_q_t q;
    int       n;
    int       mode;
    int       pos;
    bit       mid_paused;
    mid_paused = 1'b0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // empty string closed by an item with no byte
    q.delete();
    send_string(q, 1'b1, 1'b0);
    // ASCII and two-byte extremes, top of the three-byte range
    q = '{8'h00, 8'h7F, 8'hC2, 8'h80, 8'hDF, 8'hBF, 8'hEF, 8'hBF, 8'hBF};
    send_string(q, 1'b1, 1'b0);
    // tight first continuation after E0, F0 and F4
    q = '{8'hE0, 8'hA0, 8'h80, 8'hF0, 8'h90, 8'h80, 8'h80, 8'hF4, 8'h8F, 8'hBF, 8'hBF};
    send_string(q, 1'b0, 1'b0);
    // invalid lead byte
    q = '{8'hC1};
    send_string(q, 1'b0, 1'b0);
    // overlong after E0, also cut short
    q = '{8'hE0, 8'h9F};
    send_string(q, 1'b0, 1'b0);
    wait_for_results();
    repeat (4) @(posedge clk);

    // a long run of characters, sent back to back
    quiet = 1'b1;
    q.delete();
    repeat (200) add_char(q);
    send_string(q, 1'b0, 1'b0);
    quiet = 1'b0;

    // random strings: mostly well formed, the rest broken or noise
    while (items_sent < RANDOM_ITEMS) begin
      q.delete();
      n = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 1) : $urandom_range(1, 8);
      repeat (n) add_char(q);
      mode = $urandom_range(0, 9);
      if (mode == 7 && q.size() > 0) begin
        pos    = $urandom_range(0, q.size() - 1);
        q[pos] = 8'($urandom);
      end else if (mode == 8) begin
        add_octet(q, 8'($urandom_range(BYTE_LEAD2_MIN, BYTE_LEAD4_MAX)));
      end else if (mode == 9) begin
        q.delete();
        repeat ($urandom_range(1, 6)) add_octet(q, 8'($urandom));
      end
      send_string(q, $urandom_range(0, 3) == 0, 1'b1);
      if (!mid_paused && items_sent > RANDOM_ITEMS / 2) begin
        wait_for_results();
        repeat (4) @(posedge clk);
        mid_paused = 1'b1;
      end
    end

    wait_for_results();
    repeat (8) @(posedge clk);
    if (fail_count == 0) begin
      $display("utf8_validate_count_core_tb: clean");
    end else begin
      $display("utf8_validate_count_core_tb: errors");
    end
    $finish;
  end

endmodule : utf8_validate_count_core_tb
`default_nettype wire
